### hdl/frss_pkg.sv
// shared types and constants for the flash record slot store
package frss_pkg;

  typedef struct packed {
    logic       mode;
    logic [1:0] sector;
    logic [7:0] data_byte;
    logic       last_in;
  } frss_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       last_out;
  } frss_out_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BAD   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  localparam logic [7:0] ERASED    = 8'hFF;
  localparam int         HDR_BYTES = 2;
  localparam int         SZ_W      = 7;

  typedef enum logic [1:0] {
    CMD_FAIL,
    CMD_READ,
    CMD_WRITE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] status;
    logic [1:0] sector;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic wr_done;
  } back_stat_t;

endpackage

### hdl/frss_front.sv
// front end: takes beats, buffers record bytes and classifies requests
module frss_front #(
  parameter int MAX_RECORD  = 64,
  parameter int NUM_SECTORS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  frss_pkg::frss_in_t        in_data,
  input  logic [frss_pkg::SZ_W-1:0] record_size,
  input  frss_pkg::back_stat_t      stat,
  input  logic                      q_full,
  output logic                      push,
  output frss_pkg::cmd_t            push_cmd,
  input  logic [((MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1)-1:0] rec_raddr,
  output logic [7:0]                rec_rdata
);
  import frss_pkg::*;

  localparam int BUF_AW = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;
  localparam logic [SZ_W-1:0] MAX_R = SZ_W'(MAX_RECORD);

  logic [7:0]      rec_mem [0:MAX_RECORD-1];
  logic [7:0]      rec_rdata_r;
  logic [SZ_W-1:0] byte_count_r, byte_count_nxt;
  logic            wr_lock_r;
  logic            acc, size_bad, sec_bad;
  logic [SZ_W-1:0] n_cur;

  assign busy     = stat.clearing || q_full || wr_lock_r;
  assign acc      = start && !busy;
  assign size_bad = (record_size == '0) || (record_size > MAX_R);
  assign sec_bad  = (9'(in_data.sector) >= 9'(NUM_SECTORS));
  assign n_cur    = (byte_count_r == '1) ? byte_count_r : byte_count_r + SZ_W'(1);
  assign push     = acc && (in_data.mode || in_data.last_in);
  assign rec_rdata = rec_rdata_r;

  always_comb begin
    push_cmd.sector = in_data.sector;
    push_cmd.status = STAT_OK;
    push_cmd.kind   = in_data.mode ? CMD_READ : CMD_WRITE;
    if (size_bad || (!in_data.mode && n_cur != record_size)) begin
      push_cmd.kind   = CMD_FAIL;
      push_cmd.status = STAT_BAD;
    end else if (sec_bad) begin
      push_cmd.kind   = CMD_FAIL;
      push_cmd.status = STAT_RANGE;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (acc && !in_data.mode) begin
      byte_count_nxt = in_data.last_in ? '0 : n_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_data.mode && byte_count_r < MAX_R) begin
      rec_mem[byte_count_r[BUF_AW-1:0]] <= in_data.data_byte;
    end
    rec_rdata_r <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      wr_lock_r    <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      if (push && push_cmd.kind == CMD_WRITE) begin
        wr_lock_r <= 1'b1;
      end else if (stat.wr_done) begin
        wr_lock_r <= 1'b0;
      end
    end
  end

endmodule

### hdl/frss_queue.sv
// two-entry command queue between front and back
module frss_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  frss_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output frss_pkg::cmd_t q_cmd
);
  import frss_pkg::*;

  cmd_t       ent_r [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && q_valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && q_valid) ? 1 : 0);
    end
  end

endmodule

### hdl/frss_back.sv
// back end: sector memory and the sequencer that runs reads and writes
module frss_back #(
  parameter int SECTOR_BYTES = 4096,
  parameter int NUM_SECTORS  = 4,
  parameter int MAX_RECORD   = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [frss_pkg::SZ_W-1:0] record_size,
  input  logic                      q_valid,
  input  frss_pkg::cmd_t            q_cmd,
  output logic                      q_pop,
  output logic [((MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1)-1:0] rec_raddr,
  input  logic [7:0]                rec_rdata,
  output frss_pkg::back_stat_t      stat,
  output logic                      out_strobe,
  output frss_pkg::frss_out_t       out_data
);
  import frss_pkg::*;

  localparam int DEPTH  = NUM_SECTORS * SECTOR_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OFF_W  = $clog2(SECTOR_BYTES + 1);
  localparam int BIT_W  = OFF_W + 3;
  localparam int PRD_W  = BIT_W + SZ_W;
  localparam int TAB_W  = $clog2(MAX_RECORD + 1);
  localparam int BUF_AW = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HDR0_RD, S_HDR0_CK, S_HDR1_RD, S_HDR1_CK, S_ERASE,
    S_SCAN_RD, S_SCAN_CK, S_PICK, S_MUL, S_OFF, S_CMP_RD, S_CMP_CK,
    S_MAP_RD, S_MAP_WR, S_COPY_RD, S_COPY_WR, S_SEND_RD, S_SEND_CK
  } state_t;

  logic [OFF_W-1:0] mb_tab    [0:MAX_RECORD];
  logic [OFF_W-1:0] parts_tab [0:MAX_RECORD];

  assign mb_tab[0]    = '0;
  assign parts_tab[0] = '0;
  for (genvar g = 1; g <= MAX_RECORD; g++) begin : g_tab
    localparam int C     = ((SECTOR_BYTES - 2) * 8) / (g * 8 + 1);
    localparam int MB    = (C + 31) / 32 * 4;
    localparam int PARTS = (MB + 2 > SECTOR_BYTES) ? 0 : (SECTOR_BYTES - 2 - MB) / g;
    assign mb_tab[g]    = OFF_W'(MB);
    assign parts_tab[g] = OFF_W'(PARTS);
  end

  function automatic logic [2:0] low_bit(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  logic [7:0]       mem [0:DEPTH-1];
  logic [7:0]       rdata_r;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]       mem_wdata;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] base_r;
  logic              is_wr_r;
  logic [OFF_W-1:0]  mb_r, parts_r, cnt_r, off_r;
  logic [BIT_W-1:0]  p_r, idx_r;
  logic [PRD_W-1:0]  prod_r;
  logic              found_r, b0ok_r, fits_r, cmp_phase_r, erase_slot_r;
  logic              out_strobe_r, wr_done_r;
  frss_out_t         out_data_r;

  logic [OFF_W-1:0]  sz_m1, map_off;
  logic [BIT_W-1:0]  rd_idx, mul_a;
  logic              hdr_ok, fits_now;

  assign sz_m1    = OFF_W'(record_size) - OFF_W'(1);
  assign map_off  = OFF_W'(HDR_BYTES) + OFF_W'(idx_r >> 3);
  assign rd_idx   = found_r ? p_r - BIT_W'(1) : {mb_r, 3'b000} - BIT_W'(1);
  assign mul_a    = cmp_phase_r ? idx_r - BIT_W'(1) : idx_r;
  assign hdr_ok   = b0ok_r && (rdata_r == 8'h00);
  assign fits_now = fits_r && ((rdata_r & rec_rdata) == rec_rdata);

  assign q_pop          = (state_r == S_IDLE) && q_valid;
  assign rec_raddr      = cnt_r[BUF_AW-1:0];
  assign stat.clearing  = (state_r == S_CLEAR);
  assign stat.wr_done   = wr_done_r;
  assign out_strobe     = out_strobe_r;
  assign out_data       = out_data_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_addr_r;
    mem_wdata = ERASED;
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_HDR0_RD: mem_addr = base_r;
      S_HDR1_RD: mem_addr = base_r + ADDR_W'(1);
      S_ERASE: begin
        mem_we   = 1'b1;
        mem_addr = base_r + ADDR_W'(cnt_r);
        if (cnt_r == '0) begin
          mem_wdata = {1'b0, record_size};
        end else if (cnt_r == OFF_W'(1)) begin
          mem_wdata = 8'h00;
        end
      end
      S_SCAN_RD: mem_addr = base_r + ADDR_W'(HDR_BYTES) + ADDR_W'(cnt_r);
      S_CMP_RD, S_SEND_RD: mem_addr = base_r + ADDR_W'(off_r) + ADDR_W'(cnt_r);
      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_addr  = base_r + ADDR_W'(off_r) + ADDR_W'(cnt_r);
        mem_wdata = rec_rdata;
      end
      S_MAP_RD: mem_addr = base_r + ADDR_W'(map_off);
      S_MAP_WR: begin
        mem_we    = 1'b1;
        mem_addr  = base_r + ADDR_W'(map_off);
        mem_wdata = rdata_r & ~(8'h01 << idx_r[2:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
      wr_done_r    <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      wr_done_r    <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            base_r      <= ADDR_W'(q_cmd.sector * SECTOR_BYTES);
            is_wr_r     <= (q_cmd.kind == CMD_WRITE);
            mb_r        <= mb_tab[record_size[TAB_W-1:0]];
            parts_r     <= parts_tab[record_size[TAB_W-1:0]];
            cmp_phase_r <= 1'b0;
            case (q_cmd.kind)
              CMD_FAIL: begin
                out_strobe_r <= 1'b1;
                out_data_r   <= '{status: q_cmd.status, out_byte: 8'h00, last_out: 1'b1};
              end
              CMD_WRITE: begin
                if (parts_tab[record_size[TAB_W-1:0]] == '0) begin
                  out_strobe_r <= 1'b1;
                  out_data_r   <= '{status: STAT_BAD, out_byte: 8'h00, last_out: 1'b1};
                  wr_done_r    <= 1'b1;
                end else begin
                  state_r <= S_HDR0_RD;
                end
              end
              default: state_r <= S_HDR0_RD;
            endcase
          end
        end
        S_HDR0_RD: state_r <= S_HDR0_CK;
        S_HDR0_CK: begin
          b0ok_r  <= (rdata_r == {1'b0, record_size});
          state_r <= S_HDR1_RD;
        end
        S_HDR1_RD: state_r <= S_HDR1_CK;
        S_HDR1_CK: begin
          cnt_r <= '0;
          if (is_wr_r) begin
            erase_slot_r <= 1'b0;
            state_r      <= hdr_ok ? S_SCAN_RD : S_ERASE;
          end else if (!hdr_ok || parts_r == '0) begin
            out_strobe_r <= 1'b1;
            out_data_r   <= '{status: hdr_ok ? STAT_BAD : STAT_EMPTY, out_byte: 8'h00,
                              last_out: 1'b1};
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_ERASE: begin
          if (cnt_r == OFF_W'(SECTOR_BYTES - 1)) begin
            cnt_r <= '0;
            if (erase_slot_r) begin
              idx_r   <= '0;
              state_r <= S_MAP_RD;
            end else begin
              state_r <= S_SCAN_RD;
            end
          end else begin
            cnt_r <= cnt_r + OFF_W'(1);
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CK;
        S_SCAN_CK: begin
          if (rdata_r != 8'h00) begin
            p_r     <= {cnt_r, low_bit(rdata_r)};
            found_r <= 1'b1;
            state_r <= S_PICK;
          end else if (cnt_r == mb_r - OFF_W'(1)) begin
            found_r <= 1'b0;
            state_r <= S_PICK;
          end else begin
            cnt_r   <= cnt_r + OFF_W'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_PICK: begin
          if (!is_wr_r) begin
            if ((found_r && p_r == '0) || rd_idx >= BIT_W'(parts_r)) begin
              out_strobe_r <= 1'b1;
              out_data_r   <= '{status: STAT_EMPTY, out_byte: 8'h00, last_out: 1'b1};
              state_r      <= S_IDLE;
            end else begin
              idx_r   <= rd_idx;
              state_r <= S_MUL;
            end
          end else if (!found_r || p_r >= BIT_W'(parts_r)) begin
            erase_slot_r <= 1'b1;
            cnt_r        <= '0;
            state_r      <= S_ERASE;
          end else begin
            idx_r <= p_r;
            if (p_r != '0) begin
              cmp_phase_r <= 1'b1;
              state_r     <= S_MUL;
            end else begin
              state_r <= S_MAP_RD;
            end
          end
        end
        S_MUL: begin
          prod_r  <= PRD_W'(mul_a) * PRD_W'(record_size);
          state_r <= S_OFF;
        end
        S_OFF: begin
          off_r  <= OFF_W'(HDR_BYTES) + mb_r + OFF_W'(prod_r);
          cnt_r  <= '0;
          fits_r <= 1'b1;
          if (!is_wr_r) begin
            state_r <= S_SEND_RD;
          end else if (cmp_phase_r) begin
            state_r <= S_CMP_RD;
          end else begin
            state_r <= S_COPY_RD;
          end
        end
        S_CMP_RD: state_r <= S_CMP_CK;
        S_CMP_CK: begin
          fits_r <= fits_now;
          if (cnt_r == sz_m1) begin
            if (fits_now) idx_r <= idx_r - BIT_W'(1);
            cmp_phase_r <= 1'b0;
            state_r     <= S_MAP_RD;
          end else begin
            cnt_r   <= cnt_r + OFF_W'(1);
            state_r <= S_CMP_RD;
          end
        end
        S_MAP_RD: state_r <= S_MAP_WR;
        S_MAP_WR: state_r <= S_MUL;
        S_COPY_RD: state_r <= S_COPY_WR;
        S_COPY_WR: begin
          if (cnt_r == sz_m1) begin
            out_strobe_r <= 1'b1;
            out_data_r   <= '{status: STAT_OK, out_byte: 8'h00, last_out: 1'b1};
            wr_done_r    <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + OFF_W'(1);
            state_r <= S_COPY_RD;
          end
        end
        S_SEND_RD: state_r <= S_SEND_CK;
        S_SEND_CK: begin
          out_strobe_r <= 1'b1;
          out_data_r   <= '{status: STAT_OK, out_byte: rdata_r, last_out: cnt_r == sz_m1};
          if (cnt_r == sz_m1) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + OFF_W'(1);
            state_r <= S_SEND_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/flash_record_slot_store.sv
// top level of the flash record slot store
// A write byte without the last mark is only stored in the record buffer. A
// record end or a read goes through one single-port byte memory: header
// check, bitmap scan, for a write a compare against the previous slot and a
// bitmap update, then copy or read-back; a write may first erase a sector.
// After reset a clearing pass over all NUM_SECTORS*SECTOR_BYTES bytes holds
// busy high. Results come one per strobe and cannot be stalled; busy is also
// high while a written record is still being stored or the two-deep command
// queue is full.
module flash_record_slot_store #(
  parameter int SECTOR_BYTES = 4096,
  parameter int NUM_SECTORS  = 4,
  parameter int MAX_RECORD   = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  frss_pkg::frss_in_t        in_data,
  output logic                      out_strobe,
  output frss_pkg::frss_out_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [frss_pkg::SZ_W-1:0] cfg_record_size
);
  import frss_pkg::*;

  localparam int BUF_AW = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;

  logic [SZ_W-1:0]   record_size_r;
  logic              push, q_full, q_pop, q_valid;
  cmd_t              push_cmd, q_cmd;
  back_stat_t        stat;
  logic [BUF_AW-1:0] rec_raddr;
  logic [7:0]        rec_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      record_size_r <= cfg_record_size;
    end
  end

  frss_front #(
    .MAX_RECORD  (MAX_RECORD),
    .NUM_SECTORS (NUM_SECTORS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .record_size (record_size_r),
    .stat        (stat),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .rec_raddr   (rec_raddr),
    .rec_rdata   (rec_rdata)
  );

  frss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  frss_back #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .NUM_SECTORS  (NUM_SECTORS),
    .MAX_RECORD   (MAX_RECORD)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .record_size (record_size_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .rec_raddr   (rec_raddr),
    .rec_rdata   (rec_rdata),
    .stat        (stat),
    .out_strobe  (out_strobe),
    .out_data    (out_data)
  );

endmodule
